// File: sv/lbp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lbp_pkg
// Shared types, constants and helpers of the LED panel bit-plane packetizer.
// ----------------------------------------------------------------------------
package lbp_pkg;

  localparam int PANEL_SIDE       = 8;
  localparam int GRAY_BITS        = 3;
  localparam int PACKET_BYTES_DEF = 64;
  localparam int HDR_BYTES        = 3;
  localparam int MSG_BYTES        = GRAY_BITS * PANEL_SIDE;
  localparam int REC_BYTES        = MSG_BYTES + 2;
  localparam int MAX_PANELS       = 7;

  localparam logic [7:0] PKT_TAG = 8'h00;

  typedef struct packed {
    logic [7:0] pixel_row0;
    logic [7:0] pixel_row1;
    logic [7:0] pixel_row2;
    logic [7:0] pixel_row3;
    logic [7:0] pixel_row4;
    logic [7:0] pixel_row5;
    logic [7:0] pixel_row6;
    logic [7:0] pixel_row7;
    logic [7:0] panel_addr;
    logic       frame_end;
  } in_data_t;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       packet_last;
  } out_data_t;

  // Which byte the datapath writes into the packet store this cycle.
  typedef enum logic [2:0] {
    WR_PLANE2 = 3'd0,
    WR_PLANE1 = 3'd1,
    WR_PLANE0 = 3'd2,
    WR_ADDR   = 3'd3,
    WR_LEN    = 3'd4
  } wr_sel_t;

  typedef struct packed {
    logic    load;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    col_adv;
    logic    panel_add;
    logic    emit_start;
    logic    issue;
    logic    finish;
  } dp_cmd_t;

  typedef struct packed {
    logic last_col;
    logic send;
    logic issue_last;
    logic out_free;
  } dp_sts_t;

  // Number of panels a packet of pb bytes holds.
  function automatic int panels_fit(input int pb);
    int n;
    n = 0;
    for (int i = 0; i < MAX_PANELS; i++) begin
      if (pb > HDR_BYTES + REC_BYTES * (n + 1)) n++;
    end
    return (n == 0) ? 1 : n;
  endfunction

endpackage
`default_nettype wire

// File: sv/led_panel_bitplane_packetizer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// led_panel_bitplane_packetizer
// Packs 8x8 gray panel columns into 3-bit-plane panel messages and streams
// them out as packets, one byte per beat.
// ----------------------------------------------------------------------------
// A column is accepted in S_IDLE; S_WR_P2, S_WR_P1 and S_WR_P0 then write
// its plane bytes, one at a time, through the single write port of the
// packet store. The eighth column of a panel adds S_WR_ADDR and S_WR_LEN for
// the address and length bytes. A due packet is read from the store one byte
// per cycle while out_ready stays high (29 bytes for one panel, 55 for two),
// and no column is accepted until the last byte is in the output register.
// No clearing pass runs after reset. PACKET_BYTES sets the store depth and
// the panels per packet: one up to 55 bytes, then one more per 26, up to 7.
// ----------------------------------------------------------------------------
module led_panel_bitplane_packetizer #(
  parameter int PACKET_BYTES = lbp_pkg::PACKET_BYTES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire lbp_pkg::in_data_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output lbp_pkg::out_data_t      out_data
);

  lbp_pkg::dp_cmd_t cmd;
  lbp_pkg::dp_sts_t sts;

  lbp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lbp_datapath #(
    .PACKET_BYTES (PACKET_BYTES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
`default_nettype wire

// File: sv/lbp_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lbp_ctrl
// Sequencer: takes a column, steps the plane writes, closes the panel and
// runs the packet readout.
// ----------------------------------------------------------------------------
module lbp_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire lbp_pkg::dp_sts_t sts,
  output lbp_pkg::dp_cmd_t      cmd
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_WR_P2   = 7'b0000010,
    S_WR_P1   = 7'b0000100,
    S_WR_P0   = 7'b0001000,
    S_WR_ADDR = 7'b0010000,
    S_WR_LEN  = 7'b0100000,
    S_EMIT    = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.wr_sel     = lbp_pkg::WR_PLANE2;
    in_ready       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_WR_P2;
        end
      end
      S_WR_P2: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = lbp_pkg::WR_PLANE2;
        state_nxt  = S_WR_P1;
      end
      S_WR_P1: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = lbp_pkg::WR_PLANE1;
        state_nxt  = S_WR_P0;
      end
      S_WR_P0: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = lbp_pkg::WR_PLANE0;
        cmd.col_adv = 1'b1;
        state_nxt   = sts.last_col ? S_WR_ADDR : S_IDLE;
      end
      S_WR_ADDR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = lbp_pkg::WR_ADDR;
        state_nxt  = S_WR_LEN;
      end
      S_WR_LEN: begin
        cmd.wr_en     = 1'b1;
        cmd.wr_sel    = lbp_pkg::WR_LEN;
        cmd.panel_add = 1'b1;
        if (sts.send) begin
          cmd.emit_start = 1'b1;
          state_nxt      = S_EMIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        // issue one byte per cycle while the output register frees up
        if (sts.out_free) begin
          cmd.issue = 1'b1;
          if (sts.issue_last) begin
            cmd.finish = 1'b1;
            state_nxt  = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: sv/lbp_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lbp_datapath
// Bit-plane slicing, packet store memory, panel and packet counters and the
// output register.
// ----------------------------------------------------------------------------
module lbp_datapath #(
  parameter int PACKET_BYTES = lbp_pkg::PACKET_BYTES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire lbp_pkg::in_data_t  in_data,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output lbp_pkg::out_data_t      out_data,
  input  wire lbp_pkg::dp_cmd_t   cmd,
  output lbp_pkg::dp_sts_t        sts
);

  localparam int AW  = $clog2(PACKET_BYTES);
  localparam int FIT = lbp_pkg::panels_fit(PACKET_BYTES);
  localparam int GB  = lbp_pkg::GRAY_BITS;
  localparam int PS  = lbp_pkg::PANEL_SIDE;
  localparam int LSB = 8 - GB;

  logic [7:0]    plane_r [GB];
  logic [7:0]    plane_nxt [GB];
  logic [7:0]    pix [PS];
  logic [7:0]    addr_r;
  logic          fe_r;
  logic [2:0]    col_r;
  logic [2:0]    held_r;
  logic [7:0]    number_r;
  logic [7:0]    cnt_r;
  logic [7:0]    pos;
  logic [7:0]    wa8;
  logic [7:0]    wd;
  logic [7:0]    mem [PACKET_BYTES];
  logic [7:0]    mem_q_r;
  logic          out_valid_r;
  logic          hdr_sel_r;
  logic [7:0]    hdr_r;
  logic          last_r;
  logic [7:0]    col_off;

  // slice the column into its bit planes, row r in bit r
  always_comb begin
    pix[0] = in_data.pixel_row0;
    pix[1] = in_data.pixel_row1;
    pix[2] = in_data.pixel_row2;
    pix[3] = in_data.pixel_row3;
    pix[4] = in_data.pixel_row4;
    pix[5] = in_data.pixel_row5;
    pix[6] = in_data.pixel_row6;
    pix[7] = in_data.pixel_row7;
    for (int p = 0; p < GB; p++) begin
      for (int r = 0; r < PS; r++) begin
        plane_nxt[p][r] = pix[r][LSB + p];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int p = 0; p < GB; p++) plane_r[p] <= plane_nxt[p];
      addr_r <= in_data.panel_addr;
      fe_r   <= in_data.frame_end;
    end
  end

  // panel record start; once a panel is added this is also the packet length
  assign pos     = 8'(lbp_pkg::HDR_BYTES) + 8'(lbp_pkg::REC_BYTES) * {5'd0, held_r};
  assign col_off = {5'd0, col_r};

  always_comb begin
    wa8 = pos;
    wd  = addr_r;
    unique case (cmd.wr_sel)
      lbp_pkg::WR_PLANE2: begin
        wa8 = pos + 8'd2 + col_off;
        wd  = plane_r[GB-1];
      end
      lbp_pkg::WR_PLANE1: begin
        wa8 = pos + 8'd2 + 8'(PS) + col_off;
        wd  = plane_r[GB-2];
      end
      lbp_pkg::WR_PLANE0: begin
        wa8 = pos + 8'd2 + 8'(2 * PS) + col_off;
        wd  = plane_r[GB-3];
      end
      lbp_pkg::WR_ADDR: begin
        wa8 = pos;
        wd  = addr_r;
      end
      lbp_pkg::WR_LEN: begin
        wa8 = pos + 8'd1;
        wd  = 8'(lbp_pkg::MSG_BYTES);
      end
      default: begin
        wa8 = pos;
        wd  = addr_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) mem[wa8[AW-1:0]] <= wd;
    if (cmd.issue) mem_q_r <= mem[cnt_r[AW-1:0]];
  end

  // counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      held_r   <= '0;
      number_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (cmd.col_adv)    col_r  <= col_r + 3'd1;
      if (cmd.panel_add)  held_r <= held_r + 3'd1;
      if (cmd.emit_start) cnt_r  <= '0;
      else if (cmd.issue) cnt_r  <= cnt_r + 8'd1;
      if (cmd.finish) begin
        held_r   <= '0;
        number_r <= fe_r ? 8'd0 : number_r + 8'd1;
      end
    end
  end

  // output register; header bytes come from the tag and counters, the rest from memory
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.issue) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      hdr_sel_r <= (cnt_r < 8'(lbp_pkg::HDR_BYTES));
      priority if (cnt_r == 8'd0) begin
        hdr_r <= lbp_pkg::PKT_TAG;
      end else if (cnt_r == 8'd1) begin
        hdr_r <= number_r;
      end else begin
        hdr_r <= {5'd0, held_r};
      end
      last_r <= sts.issue_last;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_data.packet_byte = hdr_sel_r ? hdr_r : mem_q_r;
  assign out_data.packet_last = last_r;

  assign sts.last_col   = (col_r == 3'(PS - 1));
  assign sts.send       = fe_r || (({1'b0, held_r} + 4'd1) >= 4'(FIT));
  assign sts.issue_last = (cnt_r == pos - 8'd1);
  assign sts.out_free   = !out_valid_r || out_ready;

endmodule
`default_nettype wire

// File: sv/lbp_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lbp_checker
// Port-level checks on the packet stream of the packetizer.
// ----------------------------------------------------------------------------
module lbp_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire lbp_pkg::out_data_t out_data
);

  localparam int LEN1 = lbp_pkg::HDR_BYTES + lbp_pkg::REC_BYTES;
  localparam int LEN2 = lbp_pkg::HDR_BYTES + 2 * lbp_pkg::REC_BYTES;

  logic [7:0] byte_cnt_r;
  logic       beat;

  assign beat = out_valid && out_ready;

  // count beats within the current packet
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_cnt_r <= '0;
    end else if (beat) begin
      byte_cnt_r <= out_data.packet_last ? 8'd0 : byte_cnt_r + 8'd1;
    end
  end

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled beat changed");

  a_tag: assert property (@(posedge clk) disable iff (!rst_n)
    beat && byte_cnt_r == 8'd0 |-> out_data.packet_byte == lbp_pkg::PKT_TAG)
    else $error("packet does not open with its tag byte");

  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    beat && out_data.packet_last |->
      (byte_cnt_r == 8'(LEN1 - 1) || byte_cnt_r == 8'(LEN2 - 1)))
    else $error("packet length is not a whole number of panels");

endmodule

bind led_panel_bitplane_packetizer lbp_checker u_lbp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire

// File: test/tb_led_panel_bitplane_packetizer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_led_panel_bitplane_packetizer
// Feeds panel columns into the packetizer and checks every packet byte.
// A short directed table covers all-ones and all-zero panels, frame end in
// the middle of a panel, and each gray bit on its own. Random frames follow,
// with idle gaps on both sides, then at full rate.
// ----------------------------------------------------------------------------
module tb_led_panel_bitplane_packetizer;

  localparam int PKT_BYTES      = lbp_pkg::PACKET_BYTES_DEF;
  // a panel fits while more than one record of room is left after the header
  localparam int PANELS_RAW     = (PKT_BYTES - lbp_pkg::HDR_BYTES - 1) / lbp_pkg::REC_BYTES;
  localparam int PANELS_PER_PKT = (PANELS_RAW < 1) ? 1 :
                                  (PANELS_RAW > lbp_pkg::MAX_PANELS) ? lbp_pkg::MAX_PANELS :
                                  PANELS_RAW;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int PHASE_ITEMS    = 50;

  typedef struct {
    lbp_pkg::in_data_t d;
    bit                typed;
    logic [7:0]        fill;
  } stim_row_t;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  lbp_pkg::in_data_t  in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  lbp_pkg::out_data_t out_data;

  bit         stim_typed = 1'b0;
  logic [7:0] stim_fill  = 8'h00;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;

  // packetizer state as predicted
  logic [7:0]         plane_msg [lbp_pkg::MSG_BYTES];
  logic [2:0]         col_idx       = 3'd0;
  logic [7:0]         held_records [$];
  int                 panels_in_pkt = 0;
  logic [7:0]         pkt_seq       = 8'h00;
  lbp_pkg::out_data_t expected_bytes [$];
  lbp_pkg::out_data_t want_byte;

  stim_row_t  directed_rows [$];
  int         fail_count    = 0;
  int         columns_in    = 0;
  int         bytes_checked = 0;
  int         packets_seen  = 0;
  int         frames_sent   = 0;
  int         stall_cycles  = 0;

  led_panel_bitplane_packetizer #(.PACKET_BYTES(PKT_BYTES)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic stim_row_t stim(input logic [63:0] px, input logic [7:0] addr,
                                     input logic fe, input bit typed,
                                     input logic [7:0] fill);
    stim_row_t r;
    r.d     = {px, addr, fe};
    r.typed = typed;
    r.fill  = fill;
    return r;
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic last);
    lbp_pkg::out_data_t o;
    o.packet_byte = b;
    o.packet_last = last;
    expected_bytes.push_back(o);
  endtask

  // one-panel packet right after reset or a frame end, every plane byte = fill
  task automatic push_known_packet(input logic [7:0] addr, input logic [7:0] fill);
    push_byte(lbp_pkg::PKT_TAG, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(addr, 1'b0);
    push_byte(8'(lbp_pkg::MSG_BYTES), 1'b0);
    for (int k = 0; k < lbp_pkg::MSG_BYTES; k++)
      push_byte(fill, k == lbp_pkg::MSG_BYTES - 1);
  endtask

  task automatic absorb_column(input lbp_pkg::in_data_t c, input bit publish);
    logic [7:0] px [lbp_pkg::PANEL_SIDE];
    logic [7:0] plane;
    px = '{c.pixel_row0, c.pixel_row1, c.pixel_row2, c.pixel_row3,
           c.pixel_row4, c.pixel_row5, c.pixel_row6, c.pixel_row7};
    // keep the top gray bits; plane p is stored in reverse plane order
    for (int p = 0; p < lbp_pkg::GRAY_BITS; p++) begin
      for (int r = 0; r < lbp_pkg::PANEL_SIDE; r++)
        plane[r] = px[r][8 - lbp_pkg::GRAY_BITS + p];
      plane_msg[(lbp_pkg::GRAY_BITS - 1 - p) * lbp_pkg::PANEL_SIDE + col_idx] = plane;
    end
    if (col_idx == 3'(lbp_pkg::PANEL_SIDE - 1)) begin
      held_records.push_back(c.panel_addr);
      held_records.push_back(8'(lbp_pkg::MSG_BYTES));
      foreach (plane_msg[k]) held_records.push_back(plane_msg[k]);
      panels_in_pkt++;
      if (c.frame_end || panels_in_pkt >= PANELS_PER_PKT) begin
        if (publish) begin
          push_byte(lbp_pkg::PKT_TAG, 1'b0);
          push_byte(pkt_seq, 1'b0);
          push_byte(8'(panels_in_pkt), 1'b0);
          foreach (held_records[k]) push_byte(held_records[k], k == held_records.size() - 1);
        end
        held_records.delete();
        panels_in_pkt = 0;
        pkt_seq = c.frame_end ? 8'h00 : pkt_seq + 8'h01;
      end
    end
    col_idx = col_idx + 3'd1;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          $error("packet_byte %h arrived with nothing expected", out_data.packet_byte);
          fail_count++;
        end else begin
          want_byte = expected_bytes.pop_front();
          if (out_data.packet_byte !== want_byte.packet_byte) begin
            $error("packet_byte: expected %h, got %h", want_byte.packet_byte,
                   out_data.packet_byte);
            fail_count++;
          end
          if (out_data.packet_last !== want_byte.packet_last) begin
            $error("packet_last: expected %b, got %b", want_byte.packet_last,
                   out_data.packet_last);
            fail_count++;
          end
          bytes_checked++;
        end
        if (out_data.packet_last) packets_seen++;
      end
      if (in_valid && in_ready) begin
        columns_in++;
        absorb_column(in_data, !stim_typed);
        if (stim_typed) push_known_packet(in_data.panel_addr, stim_fill);
      end
    end
  end

  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  // Hold valid across back-to-back beats; drop it only while idling.
  task automatic send_column(input lbp_pkg::in_data_t d, input bit typed,
                             input logic [7:0] fill);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_data    <= d;
    stim_typed <= typed;
    stim_fill  <= fill;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_pixel();
    case ($urandom_range(7))
      0:       return 8'hFF;
      1:       return 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic lbp_pkg::in_data_t random_column(input bit eighth,
                                                      input bit closes_frame,
                                                      input logic [7:0] addr);
    logic [63:0] px;
    for (int i = 0; i < lbp_pkg::PANEL_SIDE; i++) px[8 * i +: 8] = rand_pixel();
    // off the eighth column the address and frame end must not matter
    if (eighth) return {px, addr, closes_frame};
    return {px, 8'($urandom), 1'($urandom_range(5) == 0)};
  endfunction

  task automatic send_frame(input int panels);
    logic [7:0] addr;
    for (int p = 0; p < panels; p++) begin
      addr = 8'($urandom);
      for (int k = 0; k < lbp_pkg::PANEL_SIDE; k++)
        send_column(random_column(k == lbp_pkg::PANEL_SIDE - 1, p == panels - 1, addr),
                    1'b0, 8'h00);
      if (p != panels - 1 && $urandom_range(15) == 0) drain_results();
    end
    frames_sent++;
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input int items);
    int start;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    start = columns_in;
    while (columns_in - start < items) send_frame($urandom_range(1, 5));
    drain_results();
  endtask

  initial begin
    // all-ones panel, address only on the eighth column
    directed_rows.push_back(stim(64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 8'h00));
    directed_rows.push_back(stim(64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 8'h00));
    directed_rows.push_back(stim(64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 8'h00));
    directed_rows.push_back(stim(64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 8'h00));
    directed_rows.push_back(stim(64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 8'h00));
    directed_rows.push_back(stim(64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 8'h00));
    directed_rows.push_back(stim(64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 8'h00));
    directed_rows.push_back(stim(64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 1'b1, 1'b1, 8'hFF));
    // all-zero panel, stray frame end on column 3
    directed_rows.push_back(stim(64'h0000_0000_0000_0000, 8'hFF, 1'b0, 1'b0, 8'h00));
    directed_rows.push_back(stim(64'h0000_0000_0000_0000, 8'hFF, 1'b0, 1'b0, 8'h00));
    directed_rows.push_back(stim(64'h0000_0000_0000_0000, 8'hFF, 1'b0, 1'b0, 8'h00));
    directed_rows.push_back(stim(64'h0000_0000_0000_0000, 8'hFF, 1'b1, 1'b0, 8'h00));
    directed_rows.push_back(stim(64'h0000_0000_0000_0000, 8'hFF, 1'b0, 1'b0, 8'h00));
    directed_rows.push_back(stim(64'h0000_0000_0000_0000, 8'hFF, 1'b0, 1'b0, 8'h00));
    directed_rows.push_back(stim(64'h0000_0000_0000_0000, 8'hFF, 1'b0, 1'b0, 8'h00));
    directed_rows.push_back(stim(64'h0000_0000_0000_0000, 8'h00, 1'b1, 1'b1, 8'h00));
    // single gray bits and dropped low bits; panel held for the first random one
    directed_rows.push_back(stim(64'h1F20_4080_E060_A0C0, 8'h11, 1'b0, 1'b0, 8'h00));
    directed_rows.push_back(stim(64'h2040_80E0_60A0_C01F, 8'h22, 1'b0, 1'b0, 8'h00));
    directed_rows.push_back(stim(64'h4080_E060_A0C0_1F20, 8'h33, 1'b0, 1'b0, 8'h00));
    directed_rows.push_back(stim(64'h80E0_60A0_C01F_2040, 8'h44, 1'b0, 1'b0, 8'h00));
    directed_rows.push_back(stim(64'hE060_A0C0_1F20_4080, 8'h55, 1'b0, 1'b0, 8'h00));
    directed_rows.push_back(stim(64'h60A0_C01F_2040_80E0, 8'h66, 1'b0, 1'b0, 8'h00));
    directed_rows.push_back(stim(64'hA0C0_1F20_4080_E060, 8'h77, 1'b0, 1'b0, 8'h00));
    directed_rows.push_back(stim(64'hC01F_2040_80E0_60A0, 8'h5A, 1'b0, 1'b0, 8'h00));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 22;
    recv_idle_pct = 74;
    foreach (directed_rows[i])
      send_column(directed_rows[i].d, directed_rows[i].typed, directed_rows[i].fill);

    run_phase(22, 74, PHASE_ITEMS);
    run_phase(74, 22, PHASE_ITEMS);
    run_phase(0, 0, PHASE_ITEMS);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d columns in %0d random frames plus directed panels", columns_in,
             frames_sent);
    $display("checked %0d bytes in %0d packets under both idle mixes and full rate",
             bytes_checked, packets_seen);
    if (fail_count == 0 && expected_bytes.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/lbp_pkg.sv
sv/lbp_ctrl.sv
sv/lbp_datapath.sv
sv/led_panel_bitplane_packetizer.sv
sv/lbp_checker.sv
test/tb_led_panel_bitplane_packetizer.sv
